// ===== hdl/multirate_history_plotter_top_macros.svh =====
// ----------------------------------------------------------------------------
// multirate_history_plotter_top_macros
// Assertion helpers for the history plotter; each expects clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTIRATE_HISTORY_PLOTTER_TOP_MACROS_SVH
`define MULTIRATE_HISTORY_PLOTTER_TOP_MACROS_SVH

// same-cycle implication
`define MHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mhp_pkg.sv =====
// ----------------------------------------------------------------------------
// mhp_pkg
// Types, codes and fixed widths of the multirate history plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package mhp_pkg;

  localparam int SAMPLE_W = 10;
  localparam int Q_W      = 16;   // unsigned Q10.6
  localparam int COORD_W  = 10;
  localparam int TOP_W    = 11;
  localparam int SPAN_W   = 6;
  localparam int PIX_W    = 9;
  localparam int MSUM_W   = 16;
  localparam int HSUM_W   = 22;
  localparam int MTICK_W  = 6;
  localparam int HTICK_W  = 12;
  localparam int DVD_W    = 28;   // divider dividend / quotient
  localparam int DEN_W    = 17;   // divider divisor

  typedef logic [1:0]          cmd_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [2:0]          status_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [TOP_W-1:0]    top_t;
  typedef logic [SPAN_W-1:0]   span_t;
  typedef logic [Q_W-1:0]      q_t;
  typedef logic [2:0]          reg_idx_t;
  typedef logic [PIX_W-1:0]    cfg_data_t;
  typedef logic [1:0]          mode_t;

  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_RENDER = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  localparam status_t ST_STORED  = 3'd0;
  localparam status_t ST_REDRAW  = 3'd1;
  localparam status_t ST_SEGMENT = 3'd2;
  localparam status_t ST_NODATA  = 3'd3;
  localparam status_t ST_CLEARED = 3'd4;

  localparam mode_t MODE_SEC  = 2'd0;
  localparam mode_t MODE_MIN  = 2'd1;
  localparam mode_t MODE_HOUR = 2'd2;

  localparam reg_idx_t REG_MODE   = 3'd0;
  localparam reg_idx_t REG_ORG_X  = 3'd1;
  localparam reg_idx_t REG_ORG_Y  = 3'd2;
  localparam reg_idx_t REG_WIDTH  = 3'd3;
  localparam reg_idx_t REG_HEIGHT = 3'd4;

  localparam int TOP_DEN = 640;   // ceil(11*v/640) = 1.1x in Q10.6

  // x/640 = (x >> 7) / 5; the /5 is a reciprocal multiply, exact below 2^13
  localparam int TOP_PRE_SH   = 7;
  localparam int TOP_Y_W      = 13;
  localparam int TOP_RECIP    = 52429;
  localparam int TOP_RECIP_SH = 18;

endpackage

`default_nettype wire

// ===== hdl/multirate_history_plotter_top.sv =====
// ----------------------------------------------------------------------------
// multirate_history_plotter_top
// Keeps second, minute and hour histories of three particle readings in one
// synchronous RAM and turns the selected history into autoscaled segments.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | moves
//  --------+-------------------------------+-------------------------------
//  in      | in_valid / in_ready           | command word + three samples
//  out     | out_valid / out_ready         | status / segment word
//  cfg     | cfg_we, cfg_index, cfg_wdata  | register write, no wait
//
// Add: the seconds entry is written at once, then each averaged field (three
//   per minute or hour entry) is divided out and each averaged entry written.
// Render: a scan of the N entries for the max, the axis top, then per entry
//   one column and three row divisions.
// Reset: synchronous, active low; clears counts, heads, sums and ticks.
// The RAM contents are not cleared; only written entries are ever read.
// Stalls: a pending out word holds the engine in its emit state; a new in
//   word is taken whenever the engine is idle.
`default_nettype none
`include "multirate_history_plotter_top_macros.svh"

module multirate_history_plotter_top #(
  parameter int HISTORY_DEPTH  = 64,
  parameter int MINUTE_SAMPLES = 60,
  parameter int HOUR_SAMPLES   = 3600
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mhp_pkg::cmd_t      in_command,
  input  wire mhp_pkg::sample_t   in_pm1_sample,
  input  wire mhp_pkg::sample_t   in_pm25_sample,
  input  wire mhp_pkg::sample_t   in_pm10_sample,
  // result words
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mhp_pkg::status_t        out_status,
  output mhp_pkg::coord_t         out_x_start,
  output mhp_pkg::coord_t         out_x_end,
  output mhp_pkg::coord_t         out_pm1_y_start,
  output mhp_pkg::coord_t         out_pm1_y_end,
  output mhp_pkg::coord_t         out_pm25_y_start,
  output mhp_pkg::coord_t         out_pm25_y_end,
  output mhp_pkg::coord_t         out_pm10_y_start,
  output mhp_pkg::coord_t         out_pm10_y_end,
  output mhp_pkg::top_t           out_scale_top,
  output mhp_pkg::span_t          out_time_span,
  output logic                    out_last_result,
  // configuration
  input  wire logic               cfg_we,
  input  wire mhp_pkg::reg_idx_t  cfg_index,
  input  wire mhp_pkg::cfg_data_t cfg_wdata
);
  import mhp_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = AW + 1;
  localparam int MEM_DEPTH = 3 << AW;   // histories sit at {hist, slot}

  // engine states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_AVG_START = 5'd1;
  localparam logic [4:0] S_DIV       = 5'd2;
  localparam logic [4:0] S_AVG_TAKE  = 5'd3;
  localparam logic [4:0] S_AVG_WRITE = 5'd4;
  localparam logic [4:0] S_RESP      = 5'd5;
  localparam logic [4:0] S_MAX_RD    = 5'd6;
  localparam logic [4:0] S_MAX_CMP   = 5'd7;
  localparam logic [4:0] S_TOP_START = 5'd8;
  localparam logic [4:0] S_TOP_TAKE  = 5'd9;
  localparam logic [4:0] S_P_RD      = 5'd10;
  localparam logic [4:0] S_P_LATCH   = 5'd11;
  localparam logic [4:0] S_COL_START = 5'd12;
  localparam logic [4:0] S_COL_TAKE  = 5'd13;
  localparam logic [4:0] S_ROW_START = 5'd14;
  localparam logic [4:0] S_ROW_TAKE  = 5'd15;
  localparam logic [4:0] S_P_NEXT    = 5'd16;
  localparam logic [4:0] S_P_EMIT    = 5'd17;

  // configuration registers
  mode_t              dmode_r;
  logic [PIX_W-1:0]   org_x_r, org_y_r, width_r, height_r;

  // history bookkeeping
  logic [CW-1:0]      cnt_r  [3];
  logic [AW-1:0]      head_r [3];
  logic [MSUM_W-1:0]  msum_r [3];
  logic [HSUM_W-1:0]  hsum_r [3];
  logic [MTICK_W-1:0] mtick_r;
  logic [HTICK_W-1:0] htick_r;

  // engine
  logic [4:0]         state_r, ret_r;
  mode_t              hist_r;
  logic [1:0]         k_r;
  logic               hpush_r;
  status_t            resp_status_r;
  logic [2:0][Q_W-1:0] ent_r;
  logic [AW-1:0]      ptr_r;
  logic [CW-1:0]      i_r;
  q_t                 largest_r;
  top_t               top_r;
  coord_t             cur_x_r, prev_x_r;
  logic [2:0][COORD_W-1:0] cur_y_r, prev_y_r;

  // shared restoring divider
  logic [DVD_W-1:0]   dvd_r;
  logic [DEN_W-1:0]   rem_r, den_r;
  logic [4:0]         dcnt_r;

  // result register
  logic               out_valid_r;
  status_t            out_status_r;
  coord_t             out_xs_r, out_xe_r;
  logic [2:0][COORD_W-1:0] out_ys_r, out_ye_r;
  top_t               out_top_r;
  span_t              out_span_r;
  logic               out_last_r;

  // history RAM
  logic [3*Q_W-1:0]   mem [MEM_DEPTH];
  logic [3*Q_W-1:0]   rd_data_r;
  logic               mem_we;
  logic [AW+1:0]      mem_waddr;
  logic [3*Q_W-1:0]   mem_wdata;

  function automatic logic [AW-1:0] push_slot(input logic [CW-1:0] cnt,
                                              input logic [AW-1:0] head);
    logic [PW-1:0] sum;
    sum = PW'(head) + PW'(cnt);
    if (cnt >= CW'(HISTORY_DEPTH)) begin
      return head;
    end
    if (sum >= PW'(HISTORY_DEPTH)) begin
      sum = sum - PW'(HISTORY_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    return (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ---------------------------------------------------------------- decode
  logic               acc, out_free, emit_c;
  mode_t              mode_in;
  logic [2:0][SAMPLE_W-1:0] smp_in;
  logic [2:0][MSUM_W-1:0]   msum_add;
  logic [2:0][HSUM_W-1:0]   hsum_add;
  logic [MTICK_W-1:0] mtick_inc;
  logic [HTICK_W-1:0] htick_inc;
  logic               mpush_c, hpush_c, redraw_c;
  logic [CW-1:0]      cnt_cur, cnt_m1;
  logic [HSUM_W-1:0]  avg_sum;
  logic [DEN_W-1:0]   avg_den;
  q_t                 rd_q [3];
  q_t                 max_a, max_b;
  logic [Q_W:0]       t2_sum;
  top_t               t2;
  logic [31:0]        t1_prod;
  top_t               t1;
  logic [DEN_W:0]     rem_sh;
  logic               div_ge;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  // a new out word is loaded this cycle
  assign emit_c   = ((state_r == S_RESP) || (state_r == S_P_EMIT)) && out_free;
  assign mode_in  = (dmode_r > MODE_HOUR) ? MODE_HOUR : dmode_r;
  assign smp_in   = {in_pm10_sample, in_pm25_sample, in_pm1_sample};
  assign cnt_cur  = cnt_r[hist_r];
  assign cnt_m1   = cnt_cur - 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      msum_add[k] = msum_r[k] + MSUM_W'(smp_in[k]);
      hsum_add[k] = hsum_r[k] + HSUM_W'(smp_in[k]);
      rd_q[k]     = rd_data_r[k*Q_W +: Q_W];
    end
  end

  assign mtick_inc = mtick_r + 1'b1;
  assign htick_inc = htick_r + 1'b1;
  assign mpush_c   = (mtick_inc >= MTICK_W'(MINUTE_SAMPLES)) || (cnt_r[1] == '0);
  assign hpush_c   = (htick_inc >= HTICK_W'(HOUR_SAMPLES)) || (cnt_r[2] == '0);
  assign redraw_c  = (mode_in == MODE_SEC) || ((mode_in == MODE_MIN) && mpush_c) ||
                     ((mode_in == MODE_HOUR) && hpush_c);

  // average operands: sum of the history being pushed over its tick count
  always_comb begin
    if (hist_r == MODE_MIN) begin
      avg_sum = HSUM_W'(msum_r[k_r]);
      avg_den = DEN_W'(mtick_r);
    end else begin
      avg_sum = hsum_r[k_r];
      avg_den = DEN_W'(htick_r);
    end
    if (avg_den == '0) begin
      avg_den = DEN_W'(1);
    end
  end

  // largest of the three fields of the entry just read
  assign max_a  = (rd_q[0] > rd_q[1]) ? rd_q[0] : rd_q[1];
  assign max_b  = (rd_q[2] > max_a) ? rd_q[2] : max_a;
  // second axis bound: ceil(v/64) + 1
  assign t2_sum = (Q_W+1)'(largest_r) + (Q_W+1)'(63);
  assign t2     = TOP_W'(t2_sum >> 6) + 1'b1;
  // first axis bound: dvd_r holds ceil-biased 11*v >> 7, divide by 5
  assign t1_prod = 32'(dvd_r[TOP_Y_W-1:0]) * 32'(TOP_RECIP);
  assign t1      = TOP_W'(t1_prod >> TOP_RECIP_SH);

  // one quotient bit per cycle
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign div_ge = (rem_sh >= {1'b0, den_r});

  // ---------------------------------------------------------------- RAM
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (acc && (in_command == CMD_ADD)) begin
      mem_we    = 1'b1;
      mem_waddr = {MODE_SEC, push_slot(cnt_r[0], head_r[0])};
      mem_wdata = {in_pm10_sample, 6'd0, in_pm25_sample, 6'd0, in_pm1_sample, 6'd0};
    end else if (state_r == S_AVG_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = {hist_r, push_slot(cnt_r[hist_r], head_r[hist_r])};
      mem_wdata = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[{hist_r, ptr_r}];
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmode_r  <= MODE_MIN;
      org_x_r  <= '0;
      org_y_r  <= '0;
      width_r  <= PIX_W'(200);
      height_r <= PIX_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   dmode_r  <= cfg_wdata[1:0];
        REG_ORG_X:  org_x_r  <= cfg_wdata;
        REG_ORG_Y:  org_y_r  <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- engine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mtick_r     <= '0;
      htick_r     <= '0;
      for (int h = 0; h < 3; h++) begin
        cnt_r[h]  <= '0;
        head_r[h] <= '0;
        msum_r[h] <= '0;
        hsum_r[h] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && !emit_c) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            case (in_command)
              CMD_CLEAR: begin
                for (int h = 0; h < 3; h++) begin
                  cnt_r[h]  <= '0;
                  head_r[h] <= '0;
                  msum_r[h] <= '0;
                  hsum_r[h] <= '0;
                end
                mtick_r       <= '0;
                htick_r       <= '0;
                resp_status_r <= ST_CLEARED;
                state_r       <= S_RESP;
              end
              CMD_ADD: begin
                // second entry goes in now, averages follow
                if (cnt_r[0] >= CW'(HISTORY_DEPTH)) begin
                  head_r[0] <= slot_inc(head_r[0]);
                end else begin
                  cnt_r[0] <= cnt_r[0] + 1'b1;
                end
                for (int k = 0; k < 3; k++) begin
                  msum_r[k] <= msum_add[k];
                  hsum_r[k] <= hsum_add[k];
                end
                mtick_r       <= mtick_inc;
                htick_r       <= htick_inc;
                hpush_r       <= hpush_c;
                resp_status_r <= redraw_c ? ST_REDRAW : ST_STORED;
                k_r           <= '0;
                if (mpush_c) begin
                  hist_r  <= MODE_MIN;
                  state_r <= S_AVG_START;
                end else if (hpush_c) begin
                  hist_r  <= MODE_HOUR;
                  state_r <= S_AVG_START;
                end else begin
                  state_r <= S_RESP;
                end
              end
              CMD_RENDER: begin
                hist_r <= mode_in;
                if (cnt_r[mode_in] == '0) begin
                  resp_status_r <= ST_NODATA;
                  state_r       <= S_RESP;
                end else begin
                  ptr_r     <= head_r[mode_in];
                  i_r       <= '0;
                  largest_r <= '0;
                  state_r   <= S_MAX_RD;
                end
              end
              default: ;   // reserved command: dropped
            endcase
          end
        end

        S_AVG_START: begin
          dvd_r   <= {avg_sum, 6'd0};
          den_r   <= avg_den;
          rem_r   <= '0;
          dcnt_r  <= 5'(DVD_W - 1);
          ret_r   <= S_AVG_TAKE;
          state_r <= S_DIV;
        end

        S_DIV: begin
          rem_r <= div_ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
          dvd_r <= {dvd_r[DVD_W-2:0], div_ge};
          if (dcnt_r == '0) begin
            state_r <= ret_r;
          end else begin
            dcnt_r <= dcnt_r - 1'b1;
          end
        end

        S_AVG_TAKE: begin
          ent_r[k_r] <= dvd_r[Q_W-1:0];
          if (k_r == 2'd2) begin
            state_r <= S_AVG_WRITE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_AVG_START;
          end
        end

        S_AVG_WRITE: begin
          if (cnt_r[hist_r] >= CW'(HISTORY_DEPTH)) begin
            head_r[hist_r] <= slot_inc(head_r[hist_r]);
          end else begin
            cnt_r[hist_r] <= cnt_r[hist_r] + 1'b1;
          end
          if (hist_r == MODE_MIN) begin
            for (int k = 0; k < 3; k++) msum_r[k] <= '0;
            mtick_r <= '0;
          end else begin
            for (int k = 0; k < 3; k++) hsum_r[k] <= '0;
            htick_r <= '0;
          end
          k_r <= '0;
          if ((hist_r == MODE_MIN) && hpush_r) begin
            hist_r  <= MODE_HOUR;
            state_r <= S_AVG_START;
          end else begin
            state_r <= S_RESP;
          end
        end

        S_RESP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= resp_status_r;
            out_xs_r     <= '0;
            out_xe_r     <= '0;
            out_ys_r     <= '0;
            out_ye_r     <= '0;
            out_top_r    <= '0;
            out_span_r   <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        // pass one: largest value over the history
        S_MAX_RD: state_r <= S_MAX_CMP;

        S_MAX_CMP: begin
          if (max_b > largest_r) begin
            largest_r <= max_b;
          end
          if (i_r == cnt_m1) begin
            state_r <= S_TOP_START;
          end else begin
            i_r     <= i_r + 1'b1;
            ptr_r   <= slot_inc(ptr_r);
            state_r <= S_MAX_RD;
          end
        end

        S_TOP_START: begin
          dvd_r   <= DVD_W'((DVD_W'(largest_r) * DVD_W'(11) + DVD_W'(TOP_DEN - 1))
                            >> TOP_PRE_SH);
          state_r <= S_TOP_TAKE;
        end

        S_TOP_TAKE: begin
          top_r   <= (t1 > t2) ? t1 : t2;
          i_r     <= '0;
          ptr_r   <= head_r[hist_r];
          state_r <= S_P_RD;
        end

        // pass two: one point per entry, a segment per adjacent pair (one point segment for a single entry)
        S_P_RD: state_r <= S_P_LATCH;

        S_P_LATCH: begin
          ent_r   <= rd_data_r;
          state_r <= S_COL_START;
        end

        S_COL_START: begin
          k_r <= '0;
          if (cnt_m1 == '0) begin
            cur_x_r <= COORD_W'(org_x_r);
            state_r <= S_ROW_START;
          end else begin
            dvd_r   <= DVD_W'(i_r) * DVD_W'(width_r);
            den_r   <= DEN_W'(cnt_m1);
            rem_r   <= '0;
            dcnt_r  <= 5'(DVD_W - 1);
            ret_r   <= S_COL_TAKE;
            state_r <= S_DIV;
          end
        end

        S_COL_TAKE: begin
          cur_x_r <= COORD_W'(org_x_r) + dvd_r[COORD_W-1:0];
          state_r <= S_ROW_START;
        end

        S_ROW_START: begin
          dvd_r   <= DVD_W'(ent_r[k_r]) * DVD_W'(height_r);
          den_r   <= {top_r, 6'd0};
          rem_r   <= '0;
          dcnt_r  <= 5'(DVD_W - 1);
          ret_r   <= S_ROW_TAKE;
          state_r <= S_DIV;
        end

        S_ROW_TAKE: begin
          cur_y_r[k_r] <= COORD_W'(org_y_r) + COORD_W'(height_r) - dvd_r[COORD_W-1:0];
          if (k_r == 2'd2) begin
            state_r <= S_P_NEXT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_ROW_START;
          end
        end

        S_P_NEXT: begin
          if (i_r == '0) begin
            prev_x_r <= cur_x_r;
            prev_y_r <= cur_y_r;
            if (cnt_m1 == '0) begin
              state_r <= S_P_EMIT;
            end else begin
              i_r     <= i_r + 1'b1;
              ptr_r   <= slot_inc(ptr_r);
              state_r <= S_P_RD;
            end
          end else begin
            state_r <= S_P_EMIT;
          end
        end

        S_P_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_SEGMENT;
            out_xs_r     <= prev_x_r;
            out_xe_r     <= cur_x_r;
            out_ys_r     <= prev_y_r;
            out_ye_r     <= cur_y_r;
            out_top_r    <= top_r;
            out_span_r   <= SPAN_W'(cnt_m1);
            out_last_r   <= (i_r == cnt_m1);
            if (i_r == cnt_m1) begin
              state_r <= S_IDLE;
            end else begin
              prev_x_r <= cur_x_r;
              prev_y_r <= cur_y_r;
              i_r      <= i_r + 1'b1;
              ptr_r    <= slot_inc(ptr_r);
              state_r  <= S_P_RD;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_x_start      = out_xs_r;
  assign out_x_end        = out_xe_r;
  assign out_pm1_y_start  = out_ys_r[0];
  assign out_pm1_y_end    = out_ye_r[0];
  assign out_pm25_y_start = out_ys_r[1];
  assign out_pm25_y_end   = out_ye_r[1];
  assign out_pm10_y_start = out_ys_r[2];
  assign out_pm10_y_end   = out_ye_r[2];
  assign out_scale_top    = out_top_r;
  assign out_time_span    = out_span_r;
  assign out_last_result  = out_last_r;

  // ---------------------------------------------------------------- checks
  `MHP_ASSERT_NXT(a_clear_empties, acc && (in_command == CMD_CLEAR), (cnt_r[0] == '0) && (cnt_r[1] == '0) && (cnt_r[2] == '0), "clear left entries behind")
  `MHP_ASSERT_NXT(a_div_returns, (state_r == S_DIV) && (dcnt_r == '0), state_r != S_DIV, "divider did not hand back")
  `MHP_ASSERT_IMP(a_seg_has_top, out_valid_r && (out_status_r == ST_SEGMENT), out_top_r != '0, "segment with zero axis top")
  `MHP_ASSERT_IMP(a_scan_in_range, state_r == S_MAX_CMP, (i_r < cnt_cur) && (cnt_cur != '0), "max scan beyond history")

endmodule

`default_nettype wire

// ===== verif/tb_multirate_history_plotter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multirate_history_plotter_top
// Self-checking bench for the history plotter: sends add, render, clear and
// unused commands, keeps its own model of the three histories, sums and
// ticks, and checks every status and segment word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multirate_history_plotter_top;
  import mhp_pkg::*;

  localparam int DEPTH   = 64;
  localparam int MIN_N   = 60;
  localparam int HOUR_N  = 3600;
  localparam int STALL_N = 2000;   // long receiver hold-off, in cycles

  // one expected out word
  typedef struct {
    status_t status;
    coord_t  x_start;
    coord_t  x_end;
    coord_t  y[6];    // pm1 start/end, pm25 start/end, pm10 start/end
    top_t    top;
    span_t   span;
    logic    last;
  } plot_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  cmd_t      in_command = CMD_ADD;
  sample_t   in_pm1_sample = '0;
  sample_t   in_pm25_sample = '0;
  sample_t   in_pm10_sample = '0;

  logic      out_valid;
  logic      out_ready = 1'b0;
  status_t   out_status;
  coord_t    out_x_start, out_x_end;
  coord_t    out_pm1_y_start, out_pm1_y_end;
  coord_t    out_pm25_y_start, out_pm25_y_end;
  coord_t    out_pm10_y_start, out_pm10_y_end;
  top_t      out_scale_top;
  span_t     out_time_span;
  logic      out_last_result;

  logic      cfg_we = 1'b0;
  reg_idx_t  cfg_index = REG_MODE;
  cfg_data_t cfg_wdata = '0;

  multirate_history_plotter_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_pm1_sample(in_pm1_sample), .in_pm25_sample(in_pm25_sample),
    .in_pm10_sample(in_pm10_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_x_start(out_x_start), .out_x_end(out_x_end),
    .out_pm1_y_start(out_pm1_y_start), .out_pm1_y_end(out_pm1_y_end),
    .out_pm25_y_start(out_pm25_y_start), .out_pm25_y_end(out_pm25_y_end),
    .out_pm10_y_start(out_pm10_y_start), .out_pm10_y_end(out_pm10_y_end),
    .out_scale_top(out_scale_top), .out_time_span(out_time_span),
    .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow state of the plotter
  // --------------------------------------------------------------------------
  int          mode_reg, org_x, org_y, width_px, height_px;
  logic [15:0] hist_mem[3][DEPTH][3];   // [history][slot][particle], Q10.6
  int          hist_cnt[3], hist_head[3];
  int          min_sum[3], hour_sum[3];
  int          min_tick, hour_tick;

  plot_word_t  due_words[$];
  int          mismatches = 0;
  bit          calm = 0;          // no idling on either side while set
  int          stall_ticket = 0;  // bumped by the stimulus to ask for a hold-off

  function automatic void clear_histories();
    for (int h = 0; h < 3; h++) begin
      hist_cnt[h] = 0;
      hist_head[h] = 0;
      min_sum[h] = 0;
      hour_sum[h] = 0;
    end
    min_tick = 0;
    hour_tick = 0;
  endfunction

  function automatic void push_entry(int h, logic [15:0] v[3]);
    int slot;
    if (hist_cnt[h] >= DEPTH) begin
      slot = hist_head[h];
      hist_head[h] = (hist_head[h] + 1) % DEPTH;
    end else begin
      slot = (hist_head[h] + hist_cnt[h]) % DEPTH;
      hist_cnt[h]++;
    end
    for (int k = 0; k < 3; k++) hist_mem[h][slot][k] = v[k];
  endfunction

  function automatic void push_average(int h, int sums[3], int n);
    logic [15:0] v[3];
    if (n == 0) n = 1;
    for (int k = 0; k < 3; k++) v[k] = 16'((longint'(sums[k]) * 64) / n);
    push_entry(h, v);
  endfunction

  function automatic coord_t row_of(int v, int top);
    longint off;
    off = (longint'(v) * height_px) / (longint'(top) * 64);
    return coord_t'(org_y + height_px - off);
  endfunction

  // Works out the words one accepted command causes and queues them.
  function automatic void predict_plot(cmd_t cmd, int s[3]);
    plot_word_t w;
    logic [15:0] raw[3];
    int mode, cnt, head, largest, t1, t2, top, nres, a, b;
    bit redraw;
    mode = (mode_reg > 2) ? 2 : mode_reg;
    w.status = ST_STORED;
    w.x_start = '0;
    w.x_end = '0;
    foreach (w.y[j]) w.y[j] = '0;
    w.top = '0;
    w.span = '0;
    w.last = 1'b1;
    case (cmd)
      CMD_CLEAR: begin
        clear_histories();
        w.status = ST_CLEARED;
        due_words.push_back(w);
      end
      CMD_ADD: begin
        for (int k = 0; k < 3; k++) raw[k] = 16'(s[k] * 64);
        push_entry(0, raw);
        redraw = (mode == 0);
        for (int k = 0; k < 3; k++) min_sum[k] = (min_sum[k] + s[k]) & 16'hFFFF;
        min_tick = (min_tick + 1) & 6'h3F;
        if (min_tick >= MIN_N || hist_cnt[1] == 0) begin
          push_average(1, min_sum, min_tick);
          for (int k = 0; k < 3; k++) min_sum[k] = 0;
          min_tick = 0;
          if (mode == 1) redraw = 1;
        end
        for (int k = 0; k < 3; k++) hour_sum[k] = (hour_sum[k] + s[k]) & 22'h3FFFFF;
        hour_tick = (hour_tick + 1) & 12'hFFF;
        if (hour_tick >= HOUR_N || hist_cnt[2] == 0) begin
          push_average(2, hour_sum, hour_tick);
          for (int k = 0; k < 3; k++) hour_sum[k] = 0;
          hour_tick = 0;
          if (mode == 2) redraw = 1;
        end
        w.status = redraw ? ST_REDRAW : ST_STORED;
        due_words.push_back(w);
      end
      CMD_RENDER: begin
        cnt = hist_cnt[mode];
        head = hist_head[mode];
        if (cnt == 0) begin
          w.status = ST_NODATA;
          due_words.push_back(w);
        end else begin
          largest = 0;
          for (int i = 0; i < cnt; i++)
            for (int k = 0; k < 3; k++)
              if (hist_mem[mode][(head + i) % DEPTH][k] > largest)
                largest = hist_mem[mode][(head + i) % DEPTH][k];
          t1 = (11 * largest + 639) / 640;
          t2 = (largest + 63) / 64 + 1;
          top = (t1 > t2) ? t1 : t2;
          nres = (cnt > 1) ? cnt - 1 : 1;
          for (int i = 0; i < nres; i++) begin
            a = (head + i) % DEPTH;
            b = (cnt > 1) ? (head + i + 1) % DEPTH : a;
            w.status = ST_SEGMENT;
            if (cnt > 1) begin
              w.x_start = coord_t'(org_x + (i * width_px) / (cnt - 1));
              w.x_end = coord_t'(org_x + ((i + 1) * width_px) / (cnt - 1));
            end else begin
              w.x_start = coord_t'(org_x);
              w.x_end = coord_t'(org_x);
            end
            for (int k = 0; k < 3; k++) begin
              w.y[2*k] = row_of(hist_mem[mode][a][k], top);
              w.y[2*k+1] = row_of(hist_mem[mode][b][k], top);
            end
            w.top = top_t'(top);
            w.span = span_t'(cnt - 1);
            w.last = (i + 1 == nres);
            due_words.push_back(w);
          end
        end
      end
      default: ;   // unused command code: no word, no state change
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    plot_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word, status", out_status, -1);
      end else begin
        w = due_words.pop_front();
        check_field("status", out_status, w.status);
        check_field("x_start", out_x_start, w.x_start);
        check_field("x_end", out_x_end, w.x_end);
        check_field("pm1_y_start", out_pm1_y_start, w.y[0]);
        check_field("pm1_y_end", out_pm1_y_end, w.y[1]);
        check_field("pm25_y_start", out_pm25_y_start, w.y[2]);
        check_field("pm25_y_end", out_pm25_y_end, w.y[3]);
        check_field("pm10_y_start", out_pm10_y_start, w.y[4]);
        check_field("pm10_y_end", out_pm10_y_end, w.y[5]);
        check_field("scale_top", out_scale_top, w.top);
        check_field("time_span", out_time_span, w.span);
        check_field("last_result", out_last_result, w.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random idling, plus one long hold-off per ticket
  // --------------------------------------------------------------------------
  int stall_taken = 0;
  int stall_left = 0;
  int rx_idle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_ticket != stall_taken) begin
      stall_taken = stall_ticket;
      stall_left = STALL_N;
      out_ready <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0)
        rx_idle = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  // Offers one word; valid stays high afterwards until the next gap or
  // until a task that idles the input lowers it.
  task automatic send_word(cmd_t cmd, int s1, int s2, int s3);
    int gap;
    int s[3];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pm1_sample <= sample_t'(s1);
    in_pm25_sample <= sample_t'(s2);
    in_pm10_sample <= sample_t'(s3);
    do @(posedge clk); while (!in_ready);
    s[0] = s1;
    s[1] = s2;
    s[2] = s3;
    predict_plot(cmd, s);
  endtask

  task automatic send_add(int s1, int s2, int s3);
    send_word(CMD_ADD, s1, s2, s3);
  endtask

  task automatic send_random_add();
    send_word(CMD_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  task automatic send_cmd(cmd_t cmd);
    send_word(cmd, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  // Sender pause: wait for every due word, then let the engine settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (due_words.size() == 0);
    @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic write_reg(reg_idx_t idx, int val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= cfg_data_t'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:   mode_reg = val & 3;
      REG_ORG_X:  org_x = val & 9'h1FF;
      REG_ORG_Y:  org_y = val & 9'h1FF;
      REG_WIDTH:  width_px = val & 9'h1FF;
      REG_HEIGHT: height_px = val & 9'h1FF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_plot(int mode, int ox, int oy, int w, int h);
    // upper bits of the mode write are don't-care; toggle them too
    write_reg(REG_MODE, ($urandom_range(0, 127) << 2) | mode);
    write_reg(REG_ORG_X, ox);
    write_reg(REG_ORG_Y, oy);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_view();
    // reset mode is minutes, history empty: no data, then unused code
    send_cmd(CMD_RENDER);
    send_cmd(cmd_t'(2'd3));
    send_cmd(CMD_CLEAR);
    drain();
  endtask

  task automatic test_directed();
    calm = 1;
    send_add(0, 0, 0);               // first sample: own minute and hour average
    send_cmd(CMD_RENDER);            // single entry: one point segment
    send_add(1023, 1023, 1023);
    send_add(10'h2AA, 10'h155, 10'h3FF);
    send_add(10'h155, 10'h2AA, 0);
    calm = 0;
    send_cmd(cmd_t'(2'd3));
    drain();
    set_plot(MODE_SEC, 0, 0, 200, 100);
    send_cmd(CMD_RENDER);
    send_add(1, 2, 3);
    drain();
    set_plot(3, 511, 511, 511, 511);  // mode 3 behaves as hours
    send_cmd(CMD_RENDER);
    send_add(7, 8, 9);
    drain();
    set_plot(MODE_SEC, 17, 300, 0, 0);  // zero width and height
    send_cmd(CMD_RENDER);
    drain();
    set_plot(MODE_MIN, 319, 0, 1, 1);
    send_cmd(CMD_RENDER);
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_RENDER);
    drain();
  endtask

  task automatic test_random_mix(int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      if (i % 45 == 44) begin
        drain();
        set_plot($urandom_range(0, 3), $urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 511), $urandom_range(0, 511));
      end
      calm = (i % 60) < 12;
      r = $urandom_range(0, 99);
      if (r < 78) send_random_add();
      else if (r < 94) send_cmd(CMD_RENDER);
      else if (r < 97) send_cmd(cmd_t'(2'd3));
      else if (i > 150) send_cmd(CMD_CLEAR);
      else send_random_add();
    end
    calm = 0;
    drain();
  endtask

  // Receiver holds off while the sender keeps offering renders of a full
  // seconds history, so the block fills and stops taking input.
  task automatic test_backpressure();
    set_plot(MODE_SEC, 0, 10, 319, 200);
    while (hist_cnt[0] < DEPTH) send_random_add();
    drain();
    stall_ticket++;
    send_cmd(CMD_RENDER);
    send_random_add();
    send_cmd(CMD_RENDER);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    mode_reg = 1;
    org_x = 0;
    org_y = 0;
    width_px = 200;
    height_px = 100;
    clear_histories();
    @(posedge clk);
    test_reset_view();
    test_directed();
    test_random_mix(190);
    test_backpressure();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
